// ----- hw/rtl/look_at_view_matrix_core_defines.svh -----
// ----------------------------------------------------------------------------
// look_at_view_matrix_core_defines
// Assertion macros shared by the look-at view matrix RTL.
// ----------------------------------------------------------------------------
`ifndef LOOK_AT_VIEW_MATRIX_CORE_DEFINES_SVH
`define LOOK_AT_VIEW_MATRIX_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define LAV_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("look-at view core: implication check failed");
// Next-cycle implication, checked outside reset.
`define LAV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("look-at view core: next-cycle check failed");
`else
`define LAV_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define LAV_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/lav_pkg.sv -----
// ----------------------------------------------------------------------------
// lav_pkg
// Widths, types and helpers shared by the look-at view matrix pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lav_pkg;

    localparam int AX_W     = 16;   // Q2.14 axis component
    localparam int POS_W    = 24;   // Q12.12 position
    localparam int RAW_W    = 33;   // exact cross product component
    localparam int MAG_W    = 32;   // magnitude of a raw component
    localparam int MSB_W    = 5;    // bit index into a magnitude
    localparam int NRM_W    = 20;   // magnitude after range alignment
    localparam int SQ_W     = 40;
    localparam int SUM_W    = 42;
    localparam int ROOT_W   = 31;   // length, floor(sqrt(sum * 2^20))
    localparam int REM_W    = 64;   // square root remainder
    localparam int NUM_W    = 46;   // divider remainder
    localparam int Q_W      = 15;   // axis quotient magnitude
    localparam int FRAC_SH  = 24;   // numerator scale of the axis divide
    localparam int PRD_W    = 40;   // axis times eye
    localparam int DOT_W    = 42;
    localparam int RND_SH   = 14;   // Q.26 down to Q12.12

    localparam int SQRT_BITS = ROOT_W;
    localparam int DIV_BITS  = Q_W;

    localparam logic [MSB_W-1:0] NRM_TOP = MSB_W'(NRM_W - 1);
    localparam logic [Q_W-1:0]   Q_ONE   = Q_W'(1 << 14);
    localparam logic [DOT_W-1:0] RND_HALF = DOT_W'(1 << (RND_SH - 1));
    localparam logic [DOT_W-1:0] SH_POS_LIM = DOT_W'((1 << (POS_W - 1)) - 1);
    localparam logic [DOT_W-1:0] SH_NEG_LIM = DOT_W'(1 << (POS_W - 1));
    localparam logic signed [POS_W-1:0] SH_MAX = POS_W'((1 << (POS_W - 1)) - 1);
    localparam logic signed [POS_W-1:0] SH_MIN = POS_W'(1 << (POS_W - 1));

    typedef logic signed [AX_W-1:0]  t_ax;
    typedef logic signed [POS_W-1:0] t_pos;
    typedef logic signed [RAW_W-1:0] t_raw;
    typedef t_ax  [2:0] t_ax3;
    typedef t_pos [2:0] t_pos3;
    typedef t_raw [2:0] t_raw3;

    // Side data that rides along each stage.
    typedef struct packed {
        t_pos3 eye;
        t_ax3  up;
        t_ax3  back;
        t_ax3  side;
    } t_carry;

    typedef struct packed {
        t_ax3  side;
        t_ax3  tu;
        t_ax3  back;
        t_pos3 shift;
    } t_rsp;

    function automatic logic [MSB_W-1:0] f_msb(input logic [MAG_W-1:0] x);
        logic [MSB_W-1:0] p;
        p = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (x[i]) begin
                p = MSB_W'(i);
            end
        end
        return p;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lav_if.sv -----
// ----------------------------------------------------------------------------
// lav_if
// Valid/ready channels for view requests and view results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lav_req_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] eye_x;
    logic signed [23:0] eye_y;
    logic signed [23:0] eye_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic signed [15:0] upref_x;
    logic signed [15:0] upref_y;
    logic signed [15:0] upref_z;

    modport source (
        output valid, eye_x, eye_y, eye_z, dir_x, dir_y, dir_z,
               upref_x, upref_y, upref_z,
        input  ready
    );
    modport sink (
        input  valid, eye_x, eye_y, eye_z, dir_x, dir_y, dir_z,
               upref_x, upref_y, upref_z,
        output ready
    );
endinterface

interface lav_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] side_x;
    logic signed [15:0] side_y;
    logic signed [15:0] side_z;
    logic signed [15:0] true_up_x;
    logic signed [15:0] true_up_y;
    logic signed [15:0] true_up_z;
    logic signed [15:0] back_x;
    logic signed [15:0] back_y;
    logic signed [15:0] back_z;
    logic signed [23:0] shift_x;
    logic signed [23:0] shift_y;
    logic signed [23:0] shift_z;

    modport source (
        output valid, side_x, side_y, side_z, true_up_x, true_up_y, true_up_z,
               back_x, back_y, back_z, shift_x, shift_y, shift_z,
        input  ready
    );
    modport sink (
        input  valid, side_x, side_y, side_z, true_up_x, true_up_y, true_up_z,
               back_x, back_y, back_z, shift_x, shift_y, shift_z,
        output ready
    );
endinterface

`default_nettype wire

// ----- hw/rtl/lav_norm.sv -----
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined fixed-point normalize of a 3-vector: range alignment, sum of
// squares, bit-per-stage square root, bit-per-stage divide, sign restore.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "look_at_view_matrix_core_defines.svh"

module lav_norm (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  lav_pkg::t_raw3  i_vec,
    input  lav_pkg::t_carry i_carry,
    output logic            o_valid,
    output lav_pkg::t_ax3   o_vec,
    output lav_pkg::t_carry o_carry
);
    import lav_pkg::*;

    // stage 1: magnitudes
    logic                  r1_valid;
    logic [2:0][MAG_W-1:0] r1_mag;
    logic [2:0]            r1_neg;
    t_carry                r1_carry;
    logic [2:0][MAG_W-1:0] n1_mag;
    // stage 2: leading one of the largest
    logic                  r2_valid;
    logic [2:0][MAG_W-1:0] r2_mag;
    logic [2:0]            r2_neg;
    logic [MSB_W-1:0]      r2_msb;
    logic                  r2_zero;
    t_carry                r2_carry;
    // stage 3: aligned magnitudes
    logic                  r3_valid;
    logic [2:0][NRM_W-1:0] r3_mag;
    logic [2:0]            r3_neg;
    logic                  r3_zero;
    t_carry                r3_carry;
    logic [2:0][NRM_W-1:0] n3_mag;
    // stage 4: squares
    logic                  r4_valid;
    logic [2:0][SQ_W-1:0]  r4_sq;
    logic [2:0][NRM_W-1:0] r4_mag;
    logic [2:0]            r4_neg;
    logic                  r4_zero;
    t_carry                r4_carry;
    logic [SUM_W-1:0]      n_sum;

    // square root stages
    logic                  r_sq_valid [0:SQRT_BITS];
    logic [REM_W-1:0]      r_sq_d     [0:SQRT_BITS];
    logic [ROOT_W-1:0]     r_sq_root  [0:SQRT_BITS];
    logic [2:0][NRM_W-1:0] r_sq_mag   [0:SQRT_BITS];
    logic [2:0]            r_sq_neg   [0:SQRT_BITS];
    logic                  r_sq_zero  [0:SQRT_BITS];
    t_carry                r_sq_carry [0:SQRT_BITS];

    // divide stages
    logic                  r_dv_valid [0:DIV_BITS];
    logic [2:0][NUM_W-1:0] r_dv_rem   [0:DIV_BITS];
    logic [2:0][Q_W-1:0]   r_dv_q     [0:DIV_BITS];
    logic [ROOT_W-1:0]     r_dv_den   [0:DIV_BITS];
    logic [2:0]            r_dv_neg   [0:DIV_BITS];
    logic                  r_dv_zero  [0:DIV_BITS];
    t_carry                r_dv_carry [0:DIV_BITS];

    // output stage
    logic                  r_out_valid;
    logic                  r_out_zero;
    t_ax3                  r_out_vec;
    t_carry                r_out_carry;
    t_ax3                  n_out_vec;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_mag[i] = i_vec[i][RAW_W-1] ? MAG_W'(-$signed(i_vec[i]))
                                          : MAG_W'(i_vec[i]);
            n3_mag[i] = (r2_msb > NRM_TOP)
                      ? NRM_W'(r2_mag[i] >> (r2_msb - NRM_TOP))
                      : NRM_W'(r2_mag[i] << (NRM_TOP - r2_msb));
            if (r_dv_zero[DIV_BITS]) begin
                n_out_vec[i] = '0;
            end else if (r_dv_neg[DIV_BITS][i]) begin
                n_out_vec[i] = AX_W'(-$signed({1'b0, r_dv_q[DIV_BITS][i]}));
            end else begin
                n_out_vec[i] = AX_W'({1'b0, r_dv_q[DIV_BITS][i]});
            end
        end
        n_sum = SUM_W'(r4_sq[0]) + SUM_W'(r4_sq[1]) + SUM_W'(r4_sq[2]);
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k <= SQRT_BITS; k++) r_sq_valid[k] <= 1'b0;
            for (int k = 0; k <= DIV_BITS; k++)  r_dv_valid[k] <= 1'b0;
        end else if (i_en) begin
            r1_valid      <= i_valid;
            r2_valid      <= r1_valid;
            r3_valid      <= r2_valid;
            r4_valid      <= r3_valid;
            r_sq_valid[0] <= r4_valid;
            for (int k = 0; k < SQRT_BITS; k++) r_sq_valid[k+1] <= r_sq_valid[k];
            r_dv_valid[0] <= r_sq_valid[SQRT_BITS];
            for (int k = 0; k < DIV_BITS; k++)  r_dv_valid[k+1] <= r_dv_valid[k];
            r_out_valid   <= r_dv_valid[DIV_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mag   <= n1_mag;
            for (int i = 0; i < 3; i++) r1_neg[i] <= i_vec[i][RAW_W-1];
            r1_carry <= i_carry;

            r2_mag   <= r1_mag;
            r2_neg   <= r1_neg;
            r2_msb   <= f_msb(r1_mag[0] | r1_mag[1] | r1_mag[2]);
            r2_zero  <= ~|(r1_mag[0] | r1_mag[1] | r1_mag[2]);
            r2_carry <= r1_carry;

            r3_mag   <= n3_mag;
            r3_neg   <= r2_neg;
            r3_zero  <= r2_zero;
            r3_carry <= r2_carry;

            for (int i = 0; i < 3; i++) begin
                r4_sq[i] <= SQ_W'(r3_mag[i]) * SQ_W'(r3_mag[i]);
            end
            r4_mag   <= r3_mag;
            r4_neg   <= r3_neg;
            r4_zero  <= r3_zero;
            r4_carry <= r3_carry;

            r_sq_d[0]     <= REM_W'(n_sum) << NRM_W;
            r_sq_root[0]  <= '0;
            r_sq_mag[0]   <= r4_mag;
            r_sq_neg[0]   <= r4_neg;
            r_sq_zero[0]  <= r4_zero;
            r_sq_carry[0] <= r4_carry;

            for (int i = 0; i < 3; i++) begin
                r_dv_rem[0][i] <= (NUM_W'(r_sq_mag[SQRT_BITS][i]) << FRAC_SH)
                                + NUM_W'(r_sq_root[SQRT_BITS] >> 1);
            end
            r_dv_q[0]     <= '0;
            r_dv_den[0]   <= r_sq_root[SQRT_BITS];
            r_dv_neg[0]   <= r_sq_neg[SQRT_BITS];
            r_dv_zero[0]  <= r_sq_zero[SQRT_BITS];
            r_dv_carry[0] <= r_sq_carry[SQRT_BITS];

            r_out_vec   <= n_out_vec;
            r_out_zero  <= r_dv_zero[DIV_BITS];
            r_out_carry <= r_dv_carry[DIV_BITS];
        end
    end

    // one root bit per stage, most significant first
    for (genvar k = 0; k < SQRT_BITS; k++) begin : g_sqrt
        localparam int B = SQRT_BITS - 1 - k;
        logic [REM_W-1:0] w_trial;
        logic             w_take;
        always_comb begin
            w_trial = (REM_W'(r_sq_root[k]) << (B + 1)) + (REM_W'(1) << (2 * B));
            w_take  = r_sq_d[k] >= w_trial;
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq_d[k+1]     <= w_take ? r_sq_d[k] - w_trial : r_sq_d[k];
                r_sq_root[k+1]  <= w_take ? (r_sq_root[k] | (ROOT_W'(1) << B))
                                          : r_sq_root[k];
                r_sq_mag[k+1]   <= r_sq_mag[k];
                r_sq_neg[k+1]   <= r_sq_neg[k];
                r_sq_zero[k+1]  <= r_sq_zero[k];
                r_sq_carry[k+1] <= r_sq_carry[k];
            end
        end
    end

    // one quotient bit per stage, three lanes sharing the length
    for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
        localparam int J = DIV_BITS - 1 - k;
        logic [NUM_W-1:0] w_sub;
        logic [2:0]       w_take;
        always_comb begin
            w_sub = NUM_W'(r_dv_den[k]) << J;
            for (int i = 0; i < 3; i++) w_take[i] = r_dv_rem[k][i] >= w_sub;
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < 3; i++) begin
                    r_dv_rem[k+1][i] <= w_take[i] ? r_dv_rem[k][i] - w_sub
                                                  : r_dv_rem[k][i];
                    r_dv_q[k+1][i]   <= w_take[i] ? (r_dv_q[k][i] | (Q_W'(1) << J))
                                                  : r_dv_q[k][i];
                end
                r_dv_den[k+1]   <= r_dv_den[k];
                r_dv_neg[k+1]   <= r_dv_neg[k];
                r_dv_zero[k+1]  <= r_dv_zero[k];
                r_dv_carry[k+1] <= r_dv_carry[k];
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_vec   = r_out_vec;
    assign o_carry = r_out_carry;

    `LAV_ASSERT_IMPLY(a_zero_axis, i_clk, i_rst_n, r_out_valid && r_out_zero, r_out_vec == '0)
    `LAV_ASSERT_IMPLY(a_quot_bound, i_clk, i_rst_n, r_dv_valid[DIV_BITS] && !r_dv_zero[DIV_BITS], (r_dv_q[DIV_BITS][0] <= Q_ONE) && (r_dv_q[DIV_BITS][1] <= Q_ONE) && (r_dv_q[DIV_BITS][2] <= Q_ONE))
    `LAV_ASSERT_NEXT(a_sqrt_moves, i_clk, i_rst_n, i_en && r_sq_valid[0], r_sq_valid[1])

endmodule

`default_nettype wire

// ----- hw/rtl/lav_cross.sv -----
// ----------------------------------------------------------------------------
// lav_cross
// Two-stage exact cross product of two Q2.14 vectors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lav_cross (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  lav_pkg::t_ax3   i_a,
    input  lav_pkg::t_ax3   i_b,
    input  lav_pkg::t_carry i_carry,
    output logic            o_valid,
    output lav_pkg::t_raw3  o_vec,
    output lav_pkg::t_carry o_carry
);
    import lav_pkg::*;

    localparam int P_W = 2 * AX_W;

    logic                      r1_valid;
    logic signed [5:0][P_W-1:0] r1_prod;
    t_carry                    r1_carry;
    logic                      r2_valid;
    t_raw3                     r2_vec;
    t_carry                    r2_carry;

    function automatic logic signed [P_W-1:0] f_mul(input t_ax a, input t_ax b);
        return P_W'($signed(a)) * P_W'($signed(b));
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_prod[0] <= f_mul(i_a[1], i_b[2]);
            r1_prod[1] <= f_mul(i_a[2], i_b[1]);
            r1_prod[2] <= f_mul(i_a[2], i_b[0]);
            r1_prod[3] <= f_mul(i_a[0], i_b[2]);
            r1_prod[4] <= f_mul(i_a[0], i_b[1]);
            r1_prod[5] <= f_mul(i_a[1], i_b[0]);
            r1_carry   <= i_carry;
            for (int i = 0; i < 3; i++) begin
                r2_vec[i] <= RAW_W'($signed(r1_prod[2*i]))
                           - RAW_W'($signed(r1_prod[2*i+1]));
            end
            r2_carry <= r1_carry;
        end
    end

    assign o_valid = r2_valid;
    assign o_vec   = r2_vec;
    assign o_carry = r2_carry;

endmodule

`default_nettype wire

// ----- hw/rtl/lav_dot.sv -----
// ----------------------------------------------------------------------------
// lav_dot
// Translation column: negated axis-eye dot products, rounded and saturated,
// assembled with the three axes into the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lav_dot (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  lav_pkg::t_carry i_carry,
    input  lav_pkg::t_ax3   i_tu,
    output logic            o_valid,
    output lav_pkg::t_rsp   o_rsp
);
    import lav_pkg::*;

    logic                                r1_valid;
    logic signed [2:0][2:0][PRD_W-1:0]   r1_prod;
    t_carry                              r1_carry;
    t_ax3                                r1_tu;
    logic                                r2_valid;
    logic signed [2:0][DOT_W-1:0]        r2_sum;
    t_carry                              r2_carry;
    t_ax3                                r2_tu;
    logic                                r3_valid;
    t_rsp                                r3_rsp;
    t_pos3                               n_shift;
    t_ax3                                w_axis [0:2];

    always_comb begin
        logic [DOT_W-1:0] mag;
        logic [DOT_W-1:0] q;
        w_axis[0] = i_carry.side;
        w_axis[1] = i_tu;
        w_axis[2] = i_carry.back;
        for (int a = 0; a < 3; a++) begin
            mag = r2_sum[a][DOT_W-1] ? DOT_W'(-$signed(r2_sum[a])) : DOT_W'(r2_sum[a]);
            q   = (mag + RND_HALF) >> RND_SH;
            // the dot is negated: a positive sum gives a negative shift
            if (!r2_sum[a][DOT_W-1] && (r2_sum[a] != '0)) begin
                n_shift[a] = (q > SH_NEG_LIM) ? SH_MIN : POS_W'(-$signed(q));
            end else begin
                n_shift[a] = (q > SH_POS_LIM) ? SH_MAX : POS_W'(q);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < 3; a++) begin
                for (int c = 0; c < 3; c++) begin
                    r1_prod[a][c] <= PRD_W'($signed(w_axis[a][c]))
                                   * PRD_W'($signed(i_carry.eye[c]));
                end
            end
            r1_carry <= i_carry;
            r1_tu    <= i_tu;
            for (int a = 0; a < 3; a++) begin
                r2_sum[a] <= DOT_W'($signed(r1_prod[a][0]))
                           + DOT_W'($signed(r1_prod[a][1]))
                           + DOT_W'($signed(r1_prod[a][2]));
            end
            r2_carry     <= r1_carry;
            r2_tu        <= r1_tu;
            r3_rsp.side  <= r2_carry.side;
            r3_rsp.tu    <= r2_tu;
            r3_rsp.back  <= r2_carry.back;
            r3_rsp.shift <= n_shift;
        end
    end

    assign o_valid = r3_valid;
    assign o_rsp   = r3_rsp;

endmodule

`default_nettype wire

// ----- hw/rtl/look_at_view_matrix_core.sv -----
// ----------------------------------------------------------------------------
// look_at_view_matrix_core
// Fixed-point look-at view basis and translation, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one view request (eye Q12.12, facing and up Q2.14) with
//   valid/ready; o_rsp returns side, true up and backward axes (Q2.14) and
//   the saturated translation column (Q12.12), one result per request.
//   The pipeline chains three normalize units of 53 stages each (the
//   31-stage square root and 15-stage divide make up most of each), two 2-stage
//   cross product units and a 3-stage dot/translate unit.
//   Throughput is one request per cycle while o_rsp.ready is high.
//   All stages advance together. When a result sits in the output register
//   and the receiver holds ready low, the whole pipeline freezes and
//   i_req.ready drops; nothing is dropped or repeated.
//   Reset (synchronous, active low) clears every stage valid bit; the block
//   keeps no other state and is ready right after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "look_at_view_matrix_core_defines.svh"

module look_at_view_matrix_core (
    input  logic   i_clk,
    input  logic   i_rst_n,
    lav_req_if.sink   i_req,
    lav_rsp_if.source o_rsp
);
    import lav_pkg::*;

    logic   w_en;
    t_raw3  w_back_raw;
    t_carry w_carry_in;

    logic   w_back_valid;
    t_ax3   w_back;
    t_carry w_back_carry;
    t_carry w_x1_carry_in;

    logic   w_x1_valid;
    t_raw3  w_x1_vec;
    t_carry w_x1_carry;

    logic   w_side_valid;
    t_ax3   w_side;
    t_carry w_side_carry;
    t_carry w_x2_carry_in;

    logic   w_x2_valid;
    t_raw3  w_x2_vec;
    t_carry w_x2_carry;

    logic   w_tu_valid;
    t_ax3   w_tu;
    t_carry w_tu_carry;

    logic   w_rsp_valid;
    t_rsp   w_rsp;

    assign w_en        = !w_rsp_valid || o_rsp.ready;
    assign i_req.ready = w_en;

    always_comb begin
        w_back_raw[0] = -RAW_W'($signed(i_req.dir_x));
        w_back_raw[1] = -RAW_W'($signed(i_req.dir_y));
        w_back_raw[2] = -RAW_W'($signed(i_req.dir_z));
        w_carry_in.eye[0] = i_req.eye_x;
        w_carry_in.eye[1] = i_req.eye_y;
        w_carry_in.eye[2] = i_req.eye_z;
        w_carry_in.up[0]  = i_req.upref_x;
        w_carry_in.up[1]  = i_req.upref_y;
        w_carry_in.up[2]  = i_req.upref_z;
        w_carry_in.back   = '0;
        w_carry_in.side   = '0;

        w_x1_carry_in      = w_back_carry;
        w_x1_carry_in.back = w_back;
        w_x2_carry_in      = w_side_carry;
        w_x2_carry_in.side = w_side;
    end

    lav_norm u_norm_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_req.valid),
        .i_vec   (w_back_raw),
        .i_carry (w_carry_in),
        .o_valid (w_back_valid),
        .o_vec   (w_back),
        .o_carry (w_back_carry)
    );

    // side = up x back
    lav_cross u_cross_side (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_back_valid),
        .i_a     (w_back_carry.up),
        .i_b     (w_back),
        .i_carry (w_x1_carry_in),
        .o_valid (w_x1_valid),
        .o_vec   (w_x1_vec),
        .o_carry (w_x1_carry)
    );

    lav_norm u_norm_side (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_x1_valid),
        .i_vec   (w_x1_vec),
        .i_carry (w_x1_carry),
        .o_valid (w_side_valid),
        .o_vec   (w_side),
        .o_carry (w_side_carry)
    );

    // true up = back x side
    lav_cross u_cross_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_side_valid),
        .i_a     (w_side_carry.back),
        .i_b     (w_side),
        .i_carry (w_x2_carry_in),
        .o_valid (w_x2_valid),
        .o_vec   (w_x2_vec),
        .o_carry (w_x2_carry)
    );

    lav_norm u_norm_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_x2_valid),
        .i_vec   (w_x2_vec),
        .i_carry (w_x2_carry),
        .o_valid (w_tu_valid),
        .o_vec   (w_tu),
        .o_carry (w_tu_carry)
    );

    lav_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_tu_valid),
        .i_carry (w_tu_carry),
        .i_tu    (w_tu),
        .o_valid (w_rsp_valid),
        .o_rsp   (w_rsp)
    );

    assign o_rsp.valid     = w_rsp_valid;
    assign o_rsp.side_x    = w_rsp.side[0];
    assign o_rsp.side_y    = w_rsp.side[1];
    assign o_rsp.side_z    = w_rsp.side[2];
    assign o_rsp.true_up_x = w_rsp.tu[0];
    assign o_rsp.true_up_y = w_rsp.tu[1];
    assign o_rsp.true_up_z = w_rsp.tu[2];
    assign o_rsp.back_x    = w_rsp.back[0];
    assign o_rsp.back_y    = w_rsp.back[1];
    assign o_rsp.back_z    = w_rsp.back[2];
    assign o_rsp.shift_x   = w_rsp.shift[0];
    assign o_rsp.shift_y   = w_rsp.shift[1];
    assign o_rsp.shift_z   = w_rsp.shift[2];

    `LAV_ASSERT_IMPLY(a_stall_only_on_hold, i_clk, i_rst_n, !i_req.ready, o_rsp.valid && !o_rsp.ready)
    `LAV_ASSERT_IMPLY(a_zero_back_chain, i_clk, i_rst_n, o_rsp.valid && (w_rsp.back == '0), (w_rsp.side == '0) && (w_rsp.tu == '0) && (w_rsp.shift == '0))
    `LAV_ASSERT_IMPLY(a_zero_side_chain, i_clk, i_rst_n, o_rsp.valid && (w_rsp.side == '0), (w_rsp.tu == '0) && (o_rsp.shift_x == '0) && (o_rsp.shift_y == '0))

endmodule

`default_nettype wire

// ----- tb/sv/lav_view_checker.sv -----
// ----------------------------------------------------------------------------
// lav_view_checker
// Watches the view request and result channels, predicts each view basis
// and translation column in fixed point, and compares results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lav_view_checker (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lav_req_if.sink   i_req,
    lav_rsp_if.sink   i_rsp,
    output int        o_fail_cnt,
    output int        o_pending
);
    import lav_pkg::*;

    typedef struct {
        logic signed [15:0] side [3];
        logic signed [15:0] tu [3];
        logic signed [15:0] back [3];
        logic signed [23:0] shift [3];
    } t_view;

    t_view view_q[$];

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > x) bit_v >>= 2;
        while (bit_v != 0) begin
            if (x >= res + bit_v) begin
                x -= res + bit_v;
                res = (res >> 1) + bit_v;
            end else begin
                res >>= 1;
            end
            bit_v >>= 2;
        end
        return res;
    endfunction

    function automatic void unit_vec(input longint v [3], output longint r [3]);
        longint unsigned mag [3];
        longint unsigned m, s, len, q;
        bit neg [3];
        m = 0;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = v[i] < 0;
            mag[i] = neg[i] ? -v[i] : v[i];
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) begin
            r = '{0, 0, 0};
            return;
        end
        while (m >= (64'd1 << 20)) begin
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
            m >>= 1;
        end
        while (m < (64'd1 << 19)) begin
            for (int i = 0; i < 3; i++) mag[i] <<= 1;
            m <<= 1;
        end
        for (int i = 0; i < 3; i++) s += mag[i] * mag[i];
        len = int_sqrt(s << 20);
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << 24) + len / 2) / len;
            if (neg[i]) begin
                if (q > 32768) q = 32768;
                r[i] = -longint'(q);
            end else begin
                if (q > 32767) q = 32767;
                r[i] = q;
            end
        end
    endfunction

    function automatic void cross_prod(input longint a [3], input longint b [3],
                                       output longint c [3]);
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic logic signed [23:0] translate(longint ax [3], longint eye [3]);
        longint t, q;
        longint unsigned mag;
        t = -(ax[0] * eye[0] + ax[1] * eye[1] + ax[2] * eye[2]);
        mag = (t < 0) ? -t : t;
        q = (mag + 8192) >> 14;
        if (t < 0) q = -q;
        if (q > 8388607) q = 8388607;
        if (q < -8388608) q = -8388608;
        return q[23:0];
    endfunction

    function automatic t_view view_basis(longint eye [3], longint dir [3], longint up [3]);
        t_view res;
        longint nb [3], b [3], sr [3], sd [3], tr [3], tu [3];
        for (int i = 0; i < 3; i++) nb[i] = -dir[i];
        unit_vec(nb, b);
        cross_prod(up, b, sr);
        unit_vec(sr, sd);
        cross_prod(b, sd, tr);
        unit_vec(tr, tu);
        for (int i = 0; i < 3; i++) begin
            res.side[i] = sd[i][15:0];
            res.tu[i]   = tu[i][15:0];
            res.back[i] = b[i][15:0];
        end
        res.shift[0] = translate(sd, eye);
        res.shift[1] = translate(tu, eye);
        res.shift[2] = translate(b, eye);
        return res;
    endfunction

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            o_fail_cnt++;
            $display("%0t %s mismatch: expected %0d actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    assign o_pending = view_q.size();

    initial o_fail_cnt = 0;

    always @(posedge i_clk) begin
        t_view exp_v;
        longint eye [3], dir [3], up [3];
        if (i_rst_n && i_req.valid && i_req.ready) begin
            eye = '{i_req.eye_x, i_req.eye_y, i_req.eye_z};
            dir = '{i_req.dir_x, i_req.dir_y, i_req.dir_z};
            up  = '{i_req.upref_x, i_req.upref_y, i_req.upref_z};
            view_q.push_back(view_basis(eye, dir, up));
        end
        if (i_rst_n && i_rsp.valid && i_rsp.ready) begin
            if (view_q.size() == 0) begin
                o_fail_cnt++;
                $display("%0t unexpected view result", $time);
            end else begin
                exp_v = view_q.pop_front();
                check_field("side_x", exp_v.side[0], i_rsp.side_x);
                check_field("side_y", exp_v.side[1], i_rsp.side_y);
                check_field("side_z", exp_v.side[2], i_rsp.side_z);
                check_field("true_up_x", exp_v.tu[0], i_rsp.true_up_x);
                check_field("true_up_y", exp_v.tu[1], i_rsp.true_up_y);
                check_field("true_up_z", exp_v.tu[2], i_rsp.true_up_z);
                check_field("back_x", exp_v.back[0], i_rsp.back_x);
                check_field("back_y", exp_v.back[1], i_rsp.back_y);
                check_field("back_z", exp_v.back[2], i_rsp.back_z);
                check_field("shift_x", exp_v.shift[0], i_rsp.shift_x);
                check_field("shift_y", exp_v.shift[1], i_rsp.shift_y);
                check_field("shift_z", exp_v.shift[2], i_rsp.shift_z);
            end
        end
    end
endmodule

// ----- tb/sv/tb_look_at_view_matrix_core.sv -----
// ----------------------------------------------------------------------------
// tb_look_at_view_matrix_core
// Drives directed and random view requests with random gaps and result
// stalls; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_look_at_view_matrix_core;
    localparam int LATENCY = 166;
    localparam int WDOG_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_cnt;
    int   pending;
    int   idle_cycles = 0;
    bit   timed_out = 0;

    lav_req_if req_if ();
    lav_rsp_if rsp_if ();

    look_at_view_matrix_core u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_rsp  (rsp_if.source)
    );

    lav_view_checker u_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_if.sink),
        .i_rsp     (rsp_if.sink),
        .o_fail_cnt(fail_cnt),
        .o_pending (pending)
    );

    always #10 i_clk = ~i_clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Stall profile changes by phase so some stretches run back to back.
    int stall_mode = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (stall_mode == 0) begin
            rsp_if.ready <= 1'b1;
        end else begin
            rsp_if.ready <= (gap_len() == 0);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || rsp_if.valid && rsp_if.ready)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_LIMIT) timed_out <= 1;
    end

    function automatic logic signed [15:0] rnd_dir(int sel);
        case (sel)
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return $urandom_range(0, 1) ? 16'sh4000 : -16'sh4000;
            4: return $signed(16'($urandom_range(0, 255))) - 16'sd128;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [23:0] rnd_eye();
        case ($urandom_range(0, 4))
            0: return 24'sh800000;
            1: return 24'sh7fffff;
            2: return 24'($urandom_range(0, 2047)) - 24'sd1024;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic send(logic signed [23:0] ex, logic signed [23:0] ey,
                        logic signed [23:0] ez, logic signed [15:0] dx,
                        logic signed [15:0] dy, logic signed [15:0] dz,
                        logic signed [15:0] ux, logic signed [15:0] uy,
                        logic signed [15:0] uz, bit gaps);
        req_if.valid   <= 1'b1;
        req_if.eye_x   <= ex;
        req_if.eye_y   <= ey;
        req_if.eye_z   <= ez;
        req_if.dir_x   <= dx;
        req_if.dir_y   <= dy;
        req_if.dir_z   <= dz;
        req_if.upref_x <= ux;
        req_if.upref_y <= uy;
        req_if.upref_z <= uz;
        do @(posedge i_clk); while (!(req_if.ready && !timed_out) && !timed_out);
        if (gaps) begin
            int g;
            g = gap_len();
            if (g > 0) begin
                req_if.valid <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        logic signed [15:0] d [3], u [3];
        req_if.valid   = 1'b0;
        req_if.eye_x   = '0;
        req_if.eye_y   = '0;
        req_if.eye_z   = '0;
        req_if.dir_x   = '0;
        req_if.dir_y   = '0;
        req_if.dir_z   = '0;
        req_if.upref_x = '0;
        req_if.upref_y = '0;
        req_if.upref_z = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: axes, zero facing, up parallel or zero, extremes, overflow
        send(0, 0, 0, 0, 0, -16384, 0, 16384, 0, 0);
        send(24'sh001000, 24'sh002000, 24'sh003000, 0, 0, 0, 0, 16384, 0, 0);
        send(24'sh7fffff, 0, 0, 0, 0, 16384, 0, 0, 16384, 0);
        send(24'sh001000, 0, 0, 16384, 0, 0, 0, 0, 0, 0);
        send(24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 16'sh8000, 16'sh8000, 16'sh8000,
             0, 16384, 0, 0);
        send(24'sh800000, 24'sh800000, 24'sh800000, 16'sh7fff, 16'sh7fff, 16'sh7fff,
             16'sh8000, 16'sh7fff, 16'sh8000, 0);
        send(24'sh7fffff, 24'sh800000, 24'sh7fffff, 16'sh8000, 0, 0, 0, 16'sh8000, 0, 0);
        send(24'sh800000, 24'sh7fffff, 24'sh800000, 1, 0, 0, 0, 1, 0, 0);
        send(24'sh7fffff, 24'sh7fffff, 24'sh800000, 16'shffff, 16'sh0001, 16'shffff,
             16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
        send(24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 16'sh7fff, 16'sh8000, 16'sh7fff,
             16'sh8000, 16'sh7fff, 16'sh8000, 0);
        send(24'sh000800, 24'shfff800, 24'sh000001, 0, 16384, 0, 0, -16384, 0, 0);
        send(24'shffffff, 24'sh000001, 24'sh123456, 16'sh8000, 16'sh8000, 0,
             16'sh7fff, 16'sh7fff, 0, 0);

        for (int n = 0; n < 1550; n++) begin
            if (n % 400 == 0) stall_mode = (n / 400) % 2;
            for (int i = 0; i < 3; i++) begin
                d[i] = rnd_dir($urandom_range(0, 9));
                u[i] = rnd_dir($urandom_range(0, 9));
            end
            if ($urandom_range(0, 19) == 0) u = d;
            send(rnd_eye(), rnd_eye(), rnd_eye(), d[0], d[1], d[2], u[0], u[1], u[2],
                 (n / 200) % 3 != 1);
            if (timed_out) break;
        end
        req_if.valid <= 1'b0;
        stall_mode = 1;
        while (pending != 0 && !timed_out) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (timed_out) begin
            $display("[FAIL] regression broken");
        end else if (fail_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
